// ===== rtl/gme_pkg.sv =====
// ----------------------------------------------------------------------------
// gme_pkg
// Shared types, constants and helpers for the grayscale erode/dilate block.
// ----------------------------------------------------------------------------
package gme_pkg;

   // structuring element geometry (mask bits use a stride of seven)
   localparam int MASK_N      = 7;
   localparam int LINES       = MASK_N - 1;
   localparam int PIX_W       = 8;
   localparam int DIM_W       = 11;
   localparam int COORD_W     = 12;
   localparam int LIN_W       = 22;
   localparam int MASK_BITS_W = 49;
   localparam int MAX_HEIGHT  = 1024;

   // configuration port
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 49;

   localparam logic MODE_ERODE  = 1'b0;
   localparam logic MODE_DILATE = 1'b1;

   localparam logic [PIX_W-1:0] PAD_ERODE  = 8'hFF;
   localparam logic [PIX_W-1:0] PAD_DILATE = 8'h00;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_MODE         = 3'd0,
      CFG_MASK_ROWS    = 3'd1,
      CFG_MASK_COLS    = 3'd2,
      CFG_MASK_BITS    = 3'd3,
      CFG_FRAME_WIDTH  = 3'd4,
      CFG_FRAME_HEIGHT = 3'd5
   } cfg_idx_type;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [MASK_N-1:0][MASK_N-1:0] win_type;
   typedef pix_type [LINES-1:0] lines_type;

   // geometry that the datapath sees, settled from the registers
   typedef struct packed {
      logic                   mode;
      logic [DIM_W-1:0]       w;
      logic [DIM_W-1:0]       h;
      logic [MASK_BITS_W-1:0] emask;
   } geom_type;

   // per-item control that travels with the window
   typedef struct packed {
      logic               emit;
      logic               last;
      logic [COORD_W-1:0] rbase;
      logic [COORD_W-1:0] cbase;
   } meta_type;

   typedef struct packed {
      pix_type pix;
      logic    last;
   } result_type;

   // min for erosion, max for dilation
   function automatic pix_type pick(input logic mode, input pix_type a, input pix_type b);
      pix_type r;
      if (mode == MODE_DILATE) begin
         r = (a > b) ? a : b;
      end else begin
         r = (a < b) ? a : b;
      end
      return r;
   endfunction

   function automatic pix_type pad_of(input logic mode);
      return (mode == MODE_DILATE) ? PAD_DILATE : PAD_ERODE;
   endfunction

endpackage

// ===== rtl/gme_ifs.sv =====
// ----------------------------------------------------------------------------
// gme interfaces
// Valid/ready channels for pixel items, result items and register writes.
// ----------------------------------------------------------------------------
interface gme_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_in;
   logic       flush;

   modport source (output valid, output pixel_in, output flush, input ready);
   modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

interface gme_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface gme_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [48:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/grayscale_morphology_erode_dilate.sv =====
// ----------------------------------------------------------------------------
// grayscale_morphology_erode_dilate
// Flat structuring element erosion / dilation on a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel | dir | payload                   | notes
//  req_if  | in  | pixel_in[7:0], flush      | one item per clock while ready
//  rsp_if  | out | pixel_out[7:0], frame_last| from an 8-entry result queue
//  csr_if  | in  | index[2:0], data[48:0]    | always ready, write when idle
//
//  One item per clock while req_if.ready is high; a result passes the window and row registers, then the queue.
//  The rate is set by the line buffer memory, one column read and written per item.
//  Results trail the pixels by (mask_rows-1-mask_rows/2)*W + (mask_cols-1-mask_cols/2) items.
//  After reset and after each register write req_if.ready is low for one clock.
//  req_if.ready drops when queued plus in-flight results reach eight.
// ----------------------------------------------------------------------------
module grayscale_morphology_erode_dilate #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   gme_req_if.sink    req_if,
   gme_rsp_if.source  rsp_if,
   gme_csr_if.sink    csr_if
);
   import gme_pkg::*;

   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int FIFO_DEPTH = 8;
   localparam int FPTR_W     = 3;
   localparam int FCNT_W     = 4;

   // registers
   logic                   mode_ff;
   logic [2:0]             mask_rows_ff, mask_cols_ff;
   logic [MASK_BITS_W-1:0] mask_bits_ff;
   logic [DIM_W-1:0]       frame_width_ff, frame_height_ff;
   logic                   busy_ff;
   logic                   csr_write;

   // settled geometry
   logic [DIM_W-1:0]       w_c, h_c;
   logic [2:0]             rows_c, cols_c;
   logic [1:0]             dr_c, dc_c, dr_ff, dc_ff;
   logic [MASK_BITS_W-1:0] emask_c;
   logic [LIN_W-1:0]       total_c, lag_c, total_ff, lag_ff;
   geom_type               geom_ff;
   int                     src;

   // stream counters
   logic [LIN_W-1:0]       vin_ff, vin_in, olin_ff, olin_in;
   logic [DIM_W-1:0]       in_col_ff, in_col_in, out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic                   accept, in_frame, proc, emit, last;
   meta_type               meta;

   // pipeline and queue
   logic [2:0]             pend_ff, pend_in;
   logic [FCNT_W-1:0]      inflight;
   win_type                win;
   logic                   win_valid;
   meta_type               win_meta;
   logic                   red_valid, red_last;
   pix_type                red_pixel;
   result_type             fifo_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [FCNT_W-1:0]      count_ff;
   logic                   push, pop;

   // register writes
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_ERODE;
         mask_rows_ff    <= 3'd3;
         mask_cols_ff    <= 3'd3;
         mask_bits_ff    <= 49'd511;
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 11'd480;
         busy_ff         <= 1'b1;
      end else begin
         busy_ff <= csr_write;
         if (csr_write) begin
            case (cfg_idx_type'(csr_if.index))
               CFG_MODE:         mode_ff         <= csr_if.data[0];
               CFG_MASK_ROWS:    mask_rows_ff    <= csr_if.data[2:0];
               CFG_MASK_COLS:    mask_cols_ff    <= csr_if.data[2:0];
               CFG_MASK_BITS:    mask_bits_ff    <= csr_if.data[MASK_BITS_W-1:0];
               CFG_FRAME_WIDTH:  frame_width_ff  <= csr_if.data[DIM_W-1:0];
               CFG_FRAME_HEIGHT: frame_height_ff <= csr_if.data[DIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // clamp geometry, anchor offsets
   always_comb begin
      rows_c = (mask_rows_ff == 3'd0) ? 3'd1 : mask_rows_ff;
      cols_c = (mask_cols_ff == 3'd0) ? 3'd1 : mask_cols_ff;
      dr_c   = 2'(rows_c - 3'd1 - (rows_c >> 1));
      dc_c   = 2'(cols_c - 3'd1 - (cols_c >> 1));
      if (frame_width_ff == '0) begin
         w_c = DIM_W'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         w_c = DIM_W'(MAX_WIDTH);
      end else begin
         w_c = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_c = DIM_W'(1);
      end else if (frame_height_ff > DIM_W'(MAX_HEIGHT)) begin
         h_c = DIM_W'(MAX_HEIGHT);
      end else begin
         h_c = frame_height_ff;
      end
      total_c = LIN_W'(w_c) * LIN_W'(h_c);
      lag_c   = LIN_W'(dr_c) * LIN_W'(w_c) + LIN_W'(dc_c);
   end

   // mask remapped to window order: entry (j,m) is j rows and m columns back
   always_comb begin
      src     = 0;
      emask_c = '0;
      for (int j = 0; j < MASK_N; j++) begin
         for (int m = 0; m < MASK_N; m++) begin
            if (j < int'(rows_c) && m < int'(cols_c)) begin
               src = (int'(rows_c) - 1 - j) * MASK_N + (int'(cols_c) - 1 - m);
               emask_c[j*MASK_N+m] = mask_bits_ff[src];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      geom_ff.mode  <= mode_ff;
      geom_ff.w     <= w_c;
      geom_ff.h     <= h_c;
      geom_ff.emask <= emask_c;
      total_ff      <= total_c;
      lag_ff        <= lag_c;
      dr_ff         <= dr_c;
      dc_ff         <= dc_c;
   end

   // input handshake with room reserved for every result in flight
   assign inflight     = FCNT_W'($countones(pend_ff));
   assign req_if.ready = !busy_ff && ((count_ff + inflight) < FCNT_W'(FIFO_DEPTH));
   assign accept       = req_if.valid && req_if.ready;
   assign in_frame     = vin_ff < total_ff;
   assign proc         = accept && !(req_if.flush && in_frame);
   assign emit         = vin_ff >= (olin_ff + lag_ff);
   assign last         = olin_ff >= (total_ff - LIN_W'(1));

   always_comb begin
      meta.emit  = emit;
      meta.last  = last;
      meta.rbase = COORD_W'(out_row_ff) + COORD_W'(dr_ff);
      meta.cbase = COORD_W'(out_col_ff) + COORD_W'(dc_ff);
   end

   // position counters
   always_comb begin
      vin_in     = vin_ff;
      olin_in    = olin_ff;
      in_col_in  = in_col_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (proc) begin
         vin_in    = vin_ff + LIN_W'(1);
         in_col_in = (in_col_ff + DIM_W'(1) >= geom_ff.w) ? '0 : in_col_ff + DIM_W'(1);
         if (emit) begin
            if (last) begin
               vin_in     = '0;
               olin_in    = '0;
               in_col_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else begin
               olin_in = olin_ff + LIN_W'(1);
               if (out_col_ff + DIM_W'(1) >= geom_ff.w) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + DIM_W'(1);
               end else begin
                  out_col_in = out_col_ff + DIM_W'(1);
               end
            end
         end
      end
   end

   assign pend_in = {pend_ff[1:0], proc && emit};

   always_ff @(posedge clock) begin
      if (reset) begin
         vin_ff     <= '0;
         olin_ff    <= '0;
         in_col_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
      end else begin
         vin_ff     <= vin_in;
         olin_ff    <= olin_in;
         in_col_ff  <= in_col_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
      end
   end

   // line buffer and window
   gme_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proc),
      .pixel     (req_if.pixel_in),
      .col       (ADDR_W'(in_col_ff)),
      .meta_in   (meta),
      .win       (win),
      .out_valid (win_valid),
      .meta_out  (win_meta)
   );

   // min / max
   gme_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .win       (win),
      .meta      (win_meta),
      .geom      (geom_ff),
      .out_valid (red_valid),
      .pixel     (red_pixel),
      .last      (red_last)
   );

   // result queue
   assign push = red_valid;
   assign pop  = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FPTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + FCNT_W'(1);
            2'b01:   count_ff <= count_ff - FCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff].pix  <= red_pixel;
         fifo_ff[wr_ptr_ff].last <= red_last;
      end
   end

   assign rsp_if.valid      = count_ff != '0;
   assign rsp_if.pixel_out  = fifo_ff[rd_ptr_ff].pix;
   assign rsp_if.frame_last = fifo_ff[rd_ptr_ff].last;

   // checks
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < FCNT_W'(FIFO_DEPTH)) || pop)
      else $error("result queue overflow");

   a_pipe_align: assert property (@(posedge clock) disable iff (reset)
      red_valid == pend_ff[2])
      else $error("result pipeline out of step with its credit count");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (proc && emit && last) |=> (vin_ff == '0) && (olin_ff == '0) && (in_col_ff == '0))
      else $error("counters not cleared after the last item of a frame");

endmodule

// ===== rtl/gme_ram.sv =====
// ----------------------------------------------------------------------------
// gme_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module gme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gme_window.sv =====
// ----------------------------------------------------------------------------
// gme_window
// Line buffer memory and 7x7 window register. One column is read per item,
// the new pixel is merged in and the column is written back.
// ----------------------------------------------------------------------------
module gme_window #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  gme_pkg::pix_type             pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0] col,
   input  gme_pkg::meta_type            meta_in,
   output gme_pkg::win_type             win,
   output logic                         out_valid,
   output gme_pkg::meta_type            meta_out
);
   import gme_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int LB_W   = LINES * PIX_W;

   logic              s1_valid_ff, s1_valid_in;
   pix_type           s1_pix_ff;
   logic [ADDR_W-1:0] s1_col_ff;
   meta_type          s1_meta_ff;
   logic              fwd_ff, fwd_in;
   lines_type         fwd_data_ff;
   win_type           win_ff, win_in;
   logic              out_valid_ff, out_valid_in;
   meta_type          meta_out_ff;

   logic [LB_W-1:0]   rd_data;
   lines_type         lines;
   lines_type         wdata;
   pix_type [MASK_N-1:0] colvec;

   gme_ram #(.WIDTH(LB_W), .DEPTH(MAX_WIDTH)) u_lines (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wdata),
      .rd_en   (in_valid),
      .rd_addr (col),
      .rd_data (rd_data)
   );

   // back-to-back items on the same column (width one) take the last write
   assign fwd_in = in_valid && s1_valid_ff && (s1_col_ff == col);

   // column of the newest pixel and the rows above it
   always_comb begin
      lines     = fwd_ff ? fwd_data_ff : lines_type'(rd_data);
      colvec[0] = s1_pix_ff;
      for (int j = 1; j < MASK_N; j++) begin
         colvec[j] = lines[j-1];
      end
      for (int i = 0; i < LINES; i++) begin
         wdata[i] = colvec[i];
      end
   end

   // window shifts one column per processed item
   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int j = 0; j < MASK_N; j++) begin
            win_in[j][0] = colvec[j];
            for (int m = 1; m < MASK_N; m++) begin
               win_in[j][m] = win_ff[j][m-1];
            end
         end
      end
   end

   assign s1_valid_in  = in_valid;
   assign out_valid_in = s1_valid_ff && s1_meta_ff.emit;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         fwd_ff       <= fwd_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_pix_ff  <= pixel;
         s1_col_ff  <= col;
         s1_meta_ff <= meta_in;
      end
      if (s1_valid_ff) begin
         fwd_data_ff <= wdata;
         meta_out_ff <= s1_meta_ff;
      end
      win_ff <= win_in;
   end

   assign win       = win_ff;
   assign out_valid = out_valid_ff;
   assign meta_out  = meta_out_ff;

endmodule

// ===== rtl/gme_reduce.sv =====
// ----------------------------------------------------------------------------
// gme_reduce
// Masks and pads the window taps, then takes min or max in two stages:
// per window row, registered, then across the rows.
// ----------------------------------------------------------------------------
module gme_reduce (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  gme_pkg::win_type  win,
   input  gme_pkg::meta_type meta,
   input  gme_pkg::geom_type geom,
   output logic              out_valid,
   output gme_pkg::pix_type  pixel,
   output logic              last
);
   import gme_pkg::*;

   logic [MASK_N-1:0]    row_ok, col_ok;
   pix_type [MASK_N-1:0] racc_in, racc_ff;
   logic                 rv_ff;
   logic                 rlast_ff;
   logic                 rmode_ff;
   pix_type              pad;
   pix_type              tap;
   pix_type              acc;

   // taps inside the frame, per row and per column
   always_comb begin
      for (int j = 0; j < MASK_N; j++) begin
         row_ok[j] = (meta.rbase >= COORD_W'(j)) &&
                     ((meta.rbase - COORD_W'(j)) < COORD_W'(geom.h));
         col_ok[j] = (meta.cbase >= COORD_W'(j)) &&
                     ((meta.cbase - COORD_W'(j)) < COORD_W'(geom.w));
      end
   end

   // per-row reduction
   always_comb begin
      pad = pad_of(geom.mode);
      tap = pad;
      for (int j = 0; j < MASK_N; j++) begin
         racc_in[j] = pad;
         for (int m = 0; m < MASK_N; m++) begin
            tap = (geom.emask[j*MASK_N+m] && row_ok[j] && col_ok[m]) ? win[j][m] : pad;
            racc_in[j] = pick(geom.mode, racc_in[j], tap);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         racc_ff  <= racc_in;
         rlast_ff <= meta.last;
         rmode_ff <= geom.mode;
      end
   end

   // across the rows
   always_comb begin
      acc = racc_ff[0];
      for (int j = 1; j < MASK_N; j++) begin
         acc = pick(rmode_ff, acc, racc_ff[j]);
      end
   end

   assign out_valid = rv_ff;
   assign pixel     = acc;
   assign last      = rlast_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for grayscale_morphology_erode_dilate
// Streams whole frames with their drain items through the erode/dilate block
// under random valid/ready gaps and checks every result pixel and frame_last
// flag against a cycle-free morphology predictor kept in step with the
// register writes. A short table of hand-checked frames runs first.
// ----------------------------------------------------------------------------
module testbench;
   import gme_pkg::*;

   localparam int unsigned STORE_DEPTH = 7 * 1024;
   localparam int unsigned WIDTH_CAP   = 1024;
   localparam int          STALL_LIMIT = 4000;
   localparam int          ITEM_GOAL   = 550;

   typedef struct packed {
      pix_type pix;
      logic    last;
   } px_result_type;

   typedef struct packed {
      pix_type pix;
      logic    fl;
      logic    chk;
      pix_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   gme_req_if req_ch ();
   gme_rsp_if rsp_ch ();
   gme_csr_if csr_ch ();

   grayscale_morphology_erode_dilate uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // register mirror
   logic        cfg_mode;
   logic [2:0]  cfg_rows;
   logic [2:0]  cfg_cols;
   logic [48:0] cfg_bits;
   logic [10:0] cfg_w;
   logic [10:0] cfg_h;

   // predictor state
   pix_type       pix_store [STORE_DEPTH];
   int unsigned   in_row, in_col, out_row, out_col;
   px_result_type pending_px [$];
   logic          typed_on;
   pix_type       typed_pix;

   int  err_count;
   int  item_count;
   bit  quiet;

   // directed frames: 3x2 frame, empty mask, 3x3 window so lag is 4
   // a leading flush is ignored, one drain item is a pixel that acts as flush
   stim_row_type dir_tab [22] = '{
      '{8'h12, 1'b1, 1'b1, 8'hFF}, '{8'h00, 1'b0, 1'b1, 8'hFF},
      '{8'hFF, 1'b0, 1'b1, 8'hFF}, '{8'h80, 1'b0, 1'b1, 8'hFF},
      '{8'h01, 1'b0, 1'b1, 8'hFF}, '{8'hFE, 1'b0, 1'b1, 8'hFF},
      '{8'h7F, 1'b0, 1'b1, 8'hFF}, '{8'h00, 1'b1, 1'b1, 8'hFF},
      '{8'hAB, 1'b0, 1'b1, 8'hFF}, '{8'hFF, 1'b1, 1'b1, 8'hFF},
      '{8'h00, 1'b1, 1'b1, 8'hFF},
      '{8'h34, 1'b1, 1'b1, 8'h00}, '{8'hFF, 1'b0, 1'b1, 8'h00},
      '{8'h00, 1'b0, 1'b1, 8'h00}, '{8'h80, 1'b0, 1'b1, 8'h00},
      '{8'hFE, 1'b0, 1'b1, 8'h00}, '{8'h01, 1'b0, 1'b1, 8'h00},
      '{8'hC3, 1'b0, 1'b1, 8'h00}, '{8'hFF, 1'b1, 1'b1, 8'h00},
      '{8'h54, 1'b0, 1'b1, 8'h00}, '{8'h00, 1'b1, 1'b1, 8'h00},
      '{8'hFF, 1'b1, 1'b1, 8'h00}
   };

   function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                        input int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int unsigned drain_len();
      int unsigned w, rows, cols;
      w    = clip(cfg_w, 1, WIDTH_CAP);
      rows = clip(cfg_rows, 1, 7);
      cols = clip(cfg_cols, 1, 7);
      return (rows - 1 - rows / 2) * w + (cols - 1 - cols / 2);
   endfunction

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("mismatch: %s", msg);
   endtask

   // morphology predictor, one accepted item; took=0 when the item is ignored
   task automatic morph_step(input pix_type px, input logic fl, output bit took);
      int unsigned   w, h, rows, cols, total, lag, vin, olin;
      int            ar, ac, rr, cc;
      pix_type       pad, acc, v;
      logic          last;
      px_result_type res;
      w     = clip(cfg_w, 1, WIDTH_CAP);
      h     = clip(cfg_h, 1, 1024);
      rows  = clip(cfg_rows, 1, 7);
      cols  = clip(cfg_cols, 1, 7);
      total = w * h;
      lag   = drain_len();
      vin   = in_row * w + in_col;
      took  = 1;
      if (vin < total) begin
         if (fl) begin
            took = 0;
            return;
         end
         pix_store[vin % STORE_DEPTH] = px;
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         if (in_row < 2047) in_row++;
      end
      olin = out_row * w + out_col;
      if (vin < olin + lag) return;
      // min or max over the selected taps, padding outside the frame
      ar  = rows / 2;
      ac  = cols / 2;
      pad = (cfg_mode == MODE_DILATE) ? 8'h00 : 8'hFF;
      acc = pad;
      for (int k = 0; k < rows; k++) begin
         for (int l = 0; l < cols; l++) begin
            if (cfg_bits[k * 7 + l]) begin
               rr = int'(out_row) + k - ar;
               cc = int'(out_col) + l - ac;
               if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) v = pad;
               else v = pix_store[(rr * w + cc) % STORE_DEPTH];
               if (cfg_mode == MODE_DILATE) acc = (v > acc) ? v : acc;
               else acc = (v < acc) ? v : acc;
            end
         end
      end
      last     = (olin >= total - 1);
      res.pix  = typed_on ? typed_pix : acc;
      res.last = last;
      pending_px = {pending_px, res};
      if (last) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result check
   always @(posedge clock) begin
      px_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_px.size() == 0) begin
            flag_error($sformatf("unexpected item pix=%02h last=%0b",
                                 rsp_ch.pixel_out, rsp_ch.frame_last));
         end else begin
            want = pending_px.pop_front();
            if (rsp_ch.pixel_out !== want.pix || rsp_ch.frame_last !== want.last)
               flag_error($sformatf("pix exp=%02h act=%02h last exp=%0b act=%0b",
                                    want.pix, rsp_ch.pixel_out, want.last,
                                    rsp_ch.frame_last));
         end
      end
   end

   // result side stalls in bursts
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 8) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      int still;
      still = 0;
      while (still < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready) || reset) still = 0;
         else still++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // one pixel item, called and returning at a falling edge
   task automatic push_item(input pix_type px, input logic fl, input logic chk,
                            input pix_type want);
      int gap;
      bit took;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.pixel_in <= px;
      req_ch.flush    <= fl;
      do @(posedge clock); while (!req_ch.ready);
      typed_on  = chk;
      typed_pix = want;
      morph_step(px, fl, took);
      if (took) item_count++;
      @(negedge clock);
   endtask

   task automatic csr_write(input cfg_idx_type idx, input logic [48:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CFG_MODE:         cfg_mode = value[0];
         CFG_MASK_ROWS:    cfg_rows = value[2:0];
         CFG_MASK_COLS:    cfg_cols = value[2:0];
         CFG_MASK_BITS:    cfg_bits = value;
         CFG_FRAME_WIDTH:  cfg_w    = value[10:0];
         CFG_FRAME_HEIGHT: cfg_h    = value[10:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // wait for the block to drain, then write all registers
   task automatic reconfigure(input logic mode, input logic [2:0] rows,
                              input logic [2:0] cols, input logic [48:0] bits,
                              input logic [10:0] w, input logic [10:0] h);
      req_ch.valid <= 1'b0;
      while (pending_px.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write(CFG_MODE, {48'd0, mode});
      csr_write(CFG_MASK_ROWS, {46'd0, rows});
      csr_write(CFG_MASK_COLS, {46'd0, cols});
      csr_write(CFG_MASK_BITS, bits);
      csr_write(CFG_FRAME_WIDTH, {38'd0, w});
      csr_write(CFG_FRAME_HEIGHT, {38'd0, h});
      csr_ch.valid <= 1'b0;
   endtask

   function automatic pix_type rand_pix();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return pix_type'($urandom);
      endcase
   endfunction

   // one full frame plus drain, with ignored flushes sprinkled in
   task automatic run_frame();
      int unsigned n_px, n_drain;
      n_px    = clip(cfg_w, 1, WIDTH_CAP) * clip(cfg_h, 1, 1024);
      n_drain = drain_len();
      for (int unsigned i = 0; i < n_px; i++) begin
         if ($urandom_range(0, 19) == 0) push_item(rand_pix(), 1'b1, 1'b0, 8'h00);
         push_item(rand_pix(), 1'b0, 1'b0, 8'h00);
      end
      for (int unsigned i = 0; i < n_drain; i++) begin
         if ($urandom_range(0, 3) == 0) push_item(rand_pix(), 1'b0, 1'b0, 8'h00);
         else push_item(rand_pix(), 1'b1, 1'b0, 8'h00);
      end
   endtask

   // stimulus
   initial begin
      logic [48:0] bits;
      logic [10:0] w, h;
      err_count  = 0;
      item_count = 0;
      quiet      = 0;
      typed_on   = 0;
      typed_pix  = 8'h00;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      cfg_mode = MODE_ERODE; cfg_rows = 3'd3; cfg_cols = 3'd3;
      cfg_bits = 49'd511; cfg_w = 11'd640; cfg_h = 11'd480;
      for (int i = 0; i < STORE_DEPTH; i++) pix_store[i] = 8'h00;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.pixel_in = 8'h00;
      req_ch.flush    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CFG_MODE;
      csr_ch.data     = 49'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty mask gives the pad value in both modes
      for (int ph = 0; ph < 2; ph++) begin
         reconfigure(ph ? MODE_DILATE : MODE_ERODE, 3'd3, 3'd3, 49'd0, 11'd3, 11'd2);
         for (int i = ph * 11; i < ph * 11 + 11; i++)
            push_item(dir_tab[i].pix, dir_tab[i].fl, dir_tab[i].chk, dir_tab[i].want);
      end

      // register extremes: largest window on a one-pixel-wide frame,
      // zero mask size, zero width and height
      reconfigure(MODE_DILATE, 3'd7, 3'd7, {49{1'b1}}, 11'd1, 11'd8);
      run_frame();
      reconfigure(MODE_ERODE, 3'd0, 3'd0, {49{1'b1}}, 11'd5, 11'd1);
      run_frame();
      reconfigure(MODE_ERODE, 3'd7, 3'd1, {49{1'b1}}, 11'd0, 11'd0);
      run_frame();

      // random phases
      while (item_count < ITEM_GOAL) begin
         if (item_count > ITEM_GOAL - 150) quiet = 1;
         case ($urandom_range(0, 7))
            0: bits = 49'd0;
            1: bits = {49{1'b1}};
            default: bits = 49'({$urandom, $urandom});
         endcase
         if ($urandom_range(0, 9) == 0) begin
            w = 11'($urandom_range(0, 40));
            h = 11'($urandom_range(0, 3));
         end else begin
            w = 11'($urandom_range(1, 12));
            h = 11'($urandom_range(1, 6));
         end
         reconfigure(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     3'($urandom_range(0, 7)), bits, w, h);
         run_frame();
         if ($urandom_range(0, 2) == 0) run_frame();
      end

      // drain and finish
      req_ch.valid <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/gme_pkg.sv
rtl/gme_ifs.sv
rtl/gme_ram.sv
rtl/gme_window.sv
rtl/gme_reduce.sv
rtl/grayscale_morphology_erode_dilate.sv
tb/sv/testbench.sv
